@@ rtl/mtc_master_generator_unit_defines.svh @@
// Assertion macros shared by the MIDI time code generator RTL.
`ifndef MTC_MASTER_GENERATOR_UNIT_DEFINES_SVH
`define MTC_MASTER_GENERATOR_UNIT_DEFINES_SVH

// Checks that the antecedent implies the consequent in the same cycle.
`define MTC_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the antecedent implies the consequent in the next cycle.
`define MTC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mtc_pkg.sv @@
// Package with the codes, byte constants and types of the MIDI time code generator.
`timescale 1ns / 1ps

package mtc_pkg;

    // Command codes carried in the operation field.
    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_START    = 3'd1,
        OP_STOP     = 3'd2,
        OP_CONTINUE = 3'd3,
        OP_LOCATE   = 3'd4
    } op_t;

    // Pending transport event.
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_START    = 3'd1,
        EV_STOP     = 3'd2,
        EV_CONTINUE = 3'd3,
        EV_LOCATE   = 3'd4
    } event_t;

    // Output byte sequencer state.
    typedef enum logic [1:0] {
        BURST_IDLE,
        BURST_QF,
        BURST_FULL
    } burst_state_t;

    // MIDI bytes.
    localparam logic [7:0] QF_STATUS        = 8'hF1;
    localparam logic [7:0] SYSEX_START      = 8'hF0;
    localparam logic [7:0] SYSEX_END        = 8'hF7;
    localparam logic [7:0] SYSEX_REALTIME   = 8'h7F;
    localparam logic [7:0] SYSEX_ALL_DEV    = 8'h7F;
    localparam logic [7:0] SUB_ID_MTC       = 8'h01;
    localparam logic [7:0] SUB_ID_FULL      = 8'h01;
    localparam logic [2:0] SMPTE_24FPS_BITS = 3'b000;

    // Byte positions inside a burst.
    localparam logic [3:0] QF_LAST_IDX   = 4'd1;
    localparam logic [3:0] FULL_LAST_IDX = 4'd9;

    // Time base limits.
    localparam logic [5:0] FRAMES_PER_SEC = 6'd24;
    localparam logic [6:0] SECS_PER_MIN   = 7'd60;
    localparam logic [6:0] MINS_PER_HOUR  = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY  = 6'd24;
    localparam logic [2:0] QF_LAST_PIECE  = 3'd7;

endpackage

@@ rtl/mtc_if.sv @@
// Handshake interfaces for the command input and the MIDI byte output.
`timescale 1ns / 1ps

interface mtc_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [4:0] loc_hours;
    logic [5:0] loc_minutes;
    logic [5:0] loc_seconds;
    logic [4:0] loc_frames;

    modport source (output valid, operation, loc_hours, loc_minutes, loc_seconds,
                    loc_frames, input ready);
    modport sink (input valid, operation, loc_hours, loc_minutes, loc_seconds,
                  loc_frames, output ready);
endinterface

interface mtc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink (input valid, out_byte, last_byte, output ready);
endinterface

@@ rtl/mtc_master_generator_unit.sv @@
// MIDI time code master generator: command decode, playhead and byte sequencer.
//
// Takes one command transaction at a time (tick, start, stop, continue, locate)
// and updates the transport state in the cycle it is accepted. A tick that
// transmits loads a burst register: two bytes for a quarter frame, ten bytes
// for a full-frame SysEx after a locate. The burst register drives the output
// one byte per cycle while tx.ready is high, stalling when it is low; commands
// that transmit nothing load no burst. The next command is accepted in the
// same cycle as the final byte of the current burst, so the byte sequencer
// alone sets the rate. The master_mode register resets to 1 and is written
// through cfg_we / cfg_wdata.
`timescale 1ns / 1ps
`include "mtc_master_generator_unit_defines.svh"

module mtc_master_generator_unit
    import mtc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    mtc_cmd_if.sink           cmd,
    mtc_byte_if.source        tx
);

    // Transport state.
    logic         master_mode_reg;
    event_t       pending_reg, pending_next;
    logic [4:0]   head_hours_reg, head_hours_next;
    logic [5:0]   head_minutes_reg, head_minutes_next;
    logic [5:0]   head_seconds_reg, head_seconds_next;
    logic [4:0]   head_frames_reg, head_frames_next;
    logic [2:0]   quarter_reg, quarter_next;

    // Burst sequencer and its captured payload.
    burst_state_t burst_reg, burst_next;
    logic [3:0]   idx_reg, idx_next;
    logic [7:0]   qf_byte_reg;
    logic [4:0]   snap_hours_reg;
    logic [5:0]   snap_minutes_reg;
    logic [5:0]   snap_seconds_reg;
    logic [4:0]   snap_frames_reg;

    logic         cmd_fire;
    logic         tx_fire;
    logic         start_qf;
    logic         start_full;
    logic [7:0]   qf_byte;

    // Effective playhead for a quarter frame (cleared by a pending start).
    logic [4:0]   eff_hours;
    logic [5:0]   eff_minutes;
    logic [5:0]   eff_seconds;
    logic [4:0]   eff_frames;
    logic [3:0]   qf_nibble;

    // Two-frame advance with carries.
    logic [5:0]   adv_f;
    logic         carry_s;
    logic [6:0]   adv_s;
    logic         carry_m;
    logic [6:0]   adv_m;
    logic         carry_h;
    logic [5:0]   adv_h;
    logic [4:0]   new_frames;
    logic [5:0]   new_seconds;
    logic [5:0]   new_minutes;
    logic [4:0]   new_hours;

    // Handshakes: a new command enters once the burst is done or finishing.
    assign tx_fire   = tx.valid && tx.ready;
    assign cmd.ready = (burst_reg == BURST_IDLE) || (tx_fire && tx.last_byte);
    assign cmd_fire  = cmd.valid && cmd.ready;

    // Playhead seen by a quarter frame.
    always_comb
    begin
        if (pending_reg == EV_START)
        begin
            eff_hours   = '0;
            eff_minutes = '0;
            eff_seconds = '0;
            eff_frames  = '0;
        end
        else
        begin
            eff_hours   = head_hours_reg;
            eff_minutes = head_minutes_reg;
            eff_seconds = head_seconds_reg;
            eff_frames  = head_frames_reg;
        end
    end

    // Nibble for the current quarter-frame piece.
    always_comb
    begin
        case (quarter_reg)
            3'd0:    qf_nibble = eff_frames[3:0];
            3'd1:    qf_nibble = {3'b000, eff_frames[4]};
            3'd2:    qf_nibble = eff_seconds[3:0];
            3'd3:    qf_nibble = {2'b00, eff_seconds[5:4]};
            3'd4:    qf_nibble = eff_minutes[3:0];
            3'd5:    qf_nibble = {2'b00, eff_minutes[5:4]};
            3'd6:    qf_nibble = eff_hours[3:0];
            default: qf_nibble = {SMPTE_24FPS_BITS, eff_hours[4]};
        endcase
    end

    assign qf_byte = {1'b0, quarter_reg, qf_nibble};

    // Advance by two frames, each unit carrying at most one into the next.
    always_comb
    begin
        adv_f       = {1'b0, eff_frames} + 6'd2;
        carry_s     = (adv_f >= FRAMES_PER_SEC);
        new_frames  = carry_s ? 5'(adv_f - FRAMES_PER_SEC) : adv_f[4:0];
        adv_s       = {1'b0, eff_seconds} + {6'd0, carry_s};
        carry_m     = (adv_s >= SECS_PER_MIN);
        new_seconds = carry_m ? 6'(adv_s - SECS_PER_MIN) : adv_s[5:0];
        adv_m       = {1'b0, eff_minutes} + {6'd0, carry_m};
        carry_h     = (adv_m >= MINS_PER_HOUR);
        new_minutes = carry_h ? 6'(adv_m - MINS_PER_HOUR) : adv_m[5:0];
        adv_h       = {1'b0, eff_hours} + {5'd0, carry_h};
        new_hours   = (adv_h >= HOURS_PER_DAY) ? 5'(adv_h - HOURS_PER_DAY) : adv_h[4:0];
    end

    // Command decode and transport state update.
    always_comb
    begin
        pending_next      = pending_reg;
        head_hours_next   = head_hours_reg;
        head_minutes_next = head_minutes_reg;
        head_seconds_next = head_seconds_reg;
        head_frames_next  = head_frames_reg;
        quarter_next      = quarter_reg;
        start_qf          = 1'b0;
        start_full        = 1'b0;
        if (cmd_fire)
        begin
            case (cmd.operation)
                OP_START:    pending_next = EV_START;
                OP_STOP:     pending_next = EV_STOP;
                OP_CONTINUE: pending_next = EV_CONTINUE;
                OP_LOCATE:
                begin
                    head_hours_next   = cmd.loc_hours;
                    head_minutes_next = cmd.loc_minutes;
                    head_seconds_next = cmd.loc_seconds;
                    head_frames_next  = cmd.loc_frames;
                    if (master_mode_reg)
                    begin
                        pending_next = EV_LOCATE;
                    end
                end
                OP_TICK:
                begin
                    if (master_mode_reg)
                    begin
                        if (pending_reg == EV_LOCATE)
                        begin
                            start_full   = 1'b1;
                            pending_next = EV_STOP;
                        end
                        else if (pending_reg != EV_STOP)
                        begin
                            start_qf     = 1'b1;
                            quarter_next = quarter_reg + 3'd1;
                            if (pending_reg == EV_START)
                            begin
                                pending_next = EV_CONTINUE;
                            end
                            if (quarter_reg == QF_LAST_PIECE)
                            begin
                                head_hours_next   = new_hours;
                                head_minutes_next = new_minutes;
                                head_seconds_next = new_seconds;
                                head_frames_next  = new_frames;
                            end
                            else
                            begin
                                head_hours_next   = eff_hours;
                                head_minutes_next = eff_minutes;
                                head_seconds_next = eff_seconds;
                                head_frames_next  = eff_frames;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Burst sequencer next state.
    always_comb
    begin
        burst_next = burst_reg;
        idx_next   = idx_reg;
        if (tx_fire)
        begin
            if (tx.last_byte)
            begin
                burst_next = BURST_IDLE;
                idx_next   = '0;
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
            end
        end
        if (start_full)
        begin
            burst_next = BURST_FULL;
            idx_next   = '0;
        end
        else if (start_qf)
        begin
            burst_next = BURST_QF;
            idx_next   = '0;
        end
    end

    // Burst sequencer outputs.
    always_comb
    begin
        tx.valid     = 1'b0;
        tx.last_byte = 1'b0;
        tx.out_byte  = QF_STATUS;
        case (burst_reg)
            BURST_QF:
            begin
                tx.valid     = 1'b1;
                tx.last_byte = (idx_reg == QF_LAST_IDX);
                tx.out_byte  = (idx_reg == QF_LAST_IDX) ? qf_byte_reg : QF_STATUS;
            end
            BURST_FULL:
            begin
                tx.valid     = 1'b1;
                tx.last_byte = (idx_reg == FULL_LAST_IDX);
                case (idx_reg)
                    4'd0:    tx.out_byte = SYSEX_START;
                    4'd1:    tx.out_byte = SYSEX_REALTIME;
                    4'd2:    tx.out_byte = SYSEX_ALL_DEV;
                    4'd3:    tx.out_byte = SUB_ID_MTC;
                    4'd4:    tx.out_byte = SUB_ID_FULL;
                    4'd5:    tx.out_byte = {SMPTE_24FPS_BITS, snap_hours_reg};
                    4'd6:    tx.out_byte = {2'b00, snap_minutes_reg};
                    4'd7:    tx.out_byte = {2'b00, snap_seconds_reg};
                    4'd8:    tx.out_byte = {3'b000, snap_frames_reg};
                    default: tx.out_byte = SYSEX_END;
                endcase
            end
            default: ;
        endcase
    end

    // Control and transport registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_mode_reg  <= 1'b1;
            pending_reg      <= EV_NONE;
            head_hours_reg   <= '0;
            head_minutes_reg <= '0;
            head_seconds_reg <= '0;
            head_frames_reg  <= '0;
            quarter_reg      <= '0;
            burst_reg        <= BURST_IDLE;
            idx_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                master_mode_reg <= cfg_wdata;
            end
            pending_reg      <= pending_next;
            head_hours_reg   <= head_hours_next;
            head_minutes_reg <= head_minutes_next;
            head_seconds_reg <= head_seconds_next;
            head_frames_reg  <= head_frames_next;
            quarter_reg      <= quarter_next;
            burst_reg        <= burst_next;
            idx_reg          <= idx_next;
        end
    end

    // Burst payload captured when a burst starts.
    always_ff @(posedge clk)
    begin
        if (start_qf)
        begin
            qf_byte_reg <= qf_byte;
        end
        if (start_full)
        begin
            snap_hours_reg   <= head_hours_reg;
            snap_minutes_reg <= head_minutes_reg;
            snap_seconds_reg <= head_seconds_reg;
            snap_frames_reg  <= head_frames_reg;
        end
    end

    // A full-frame tick leaves the transport stopped and the sequencer busy.
    `MTC_ASSERT_NEXT(a_full_then_stop, start_full, (pending_reg == EV_STOP) && (burst_reg == BURST_FULL) && (idx_reg == 4'd0), "full frame did not start or stop transport")

    // The quarter index has already moved past the piece being sent.
    `MTC_ASSERT_SAME(a_qf_piece_index, burst_reg == BURST_QF, qf_byte_reg[6:4] + 3'd1 == quarter_reg, "quarter index out of step with sent piece")

    // The byte index stays inside the burst length.
    `MTC_ASSERT_SAME(a_idx_bound, burst_reg != BURST_IDLE, ((burst_reg == BURST_QF) && (idx_reg <= QF_LAST_IDX)) || ((burst_reg == BURST_FULL) && (idx_reg <= FULL_LAST_IDX)), "burst index beyond burst length")

    // After the final byte is taken the sequencer is idle or on a new burst.
    `MTC_ASSERT_NEXT(a_last_ends_burst, tx_fire && tx.last_byte, (burst_reg == BURST_IDLE) || (idx_reg == 4'd0), "burst did not end after final byte")

endmodule
